/* rtl/rsmp_pkg.sv */
// Package for the reservoir sampler: shared types, states and generator constants.
// Depends on nothing; used by rsmp_rem, reservoir_sampler_core and the test bench.
`timescale 1ns / 1ps

package rsmp_pkg;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;

    localparam logic [1:0] ACT_FREE    = 2'd0;
    localparam logic [1:0] ACT_REPLACE = 2'd1;
    localparam logic [1:0] ACT_DISCARD = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    localparam logic [0:0] REG_CAPACITY = 1'b0;
    localparam logic [0:0] REG_SEED     = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RDWAIT,
        ST_LIMIT,
        ST_DRAW,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_CHECK,
        ST_MOD,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Request to the shared remainder unit and its reply.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] rem;
    } div_rsp_t;

endpackage

/* rtl/rsmp_rem.sv */
// Bit-serial unsigned 64-bit remainder unit, one quotient bit per cycle.
// Depends on rsmp_pkg for its request and reply structs.
`timescale 1ns / 1ps

module rsmp_rem (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsmp_pkg::div_req_t req,
    output rsmp_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[63]} - {1'b0, dvs_reg};
        if (req.start) begin
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[64]) begin
                rem_next = {rem_reg[62:0], dvd_reg[63]};
            end else begin
                rem_next = trial[63:0];
            end
            dvd_next = {dvd_reg[62:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* rtl/rsmp_store.sv */
// Slot memory for all streams: payload, trial and lifetime per slot.
// One write port and one registered read port; depends on nothing.
`timescale 1ns / 1ps

module rsmp_store #(
    parameter int AW = 14
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [125:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [125:0]  rdata
);

    logic [125:0] mem [0:(1 << AW)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/reservoir_sampler_core.sv */
// Top level of the reservoir sampler: sequencer, counts, generator and APB port.
// Depends on rsmp_pkg, rsmp_rem and rsmp_store.
`timescale 1ns / 1ps

// A read item, or an offer into a stream that still has free slots, passes through
// ST_LOOK, then ST_RDWAIT or ST_WRITE, then ST_OUT before the next input beat is
// taken. An offer into a full stream draws an index. It first runs one remainder
// pass for the rejection limit. Each draw then steps through ST_DRAW, ST_MIX1,
// ST_MIX2, ST_MIX3 and ST_CHECK; one 32 by 32 bit multiplier is used three times
// per mixing step. A rejected draw goes back to ST_DRAW; an accepted one gets a
// final remainder pass in ST_MOD. Most of an offer's time goes to the bit-serial
// remainder unit. A finished result waits in its own output register, so the next
// input beat is taken meanwhile; ST_OUT holds only while an earlier result waits.
// Writing either register reloads the generator and clears all counts.

module reservoir_sampler_core #(
    parameter int MAX_CAPACITY = 1024,
    parameter int NUM_STREAMS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata: stream[3:0], sample_value[67:4], trial[98:68], life[129:99],
    // read_slot[139:130], zero fill to 144 bits.
    input  logic [143:0] s_tdata,
    // s_tuser: func.
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata: slot[9:0], out_value[73:10], out_trial[104:74], out_life[135:105],
    // stored[146:136], seen[210:147], zero fill to 216 bits.
    output logic [215:0] m_tdata,
    // m_tuser: action.
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int CW = $clog2(MAX_CAPACITY);
    localparam int CCW = CW + 1;
    localparam int AW = SW + CW;

    rsmp_pkg::state_t state_reg, state_next;

    logic [10:0] capacity_reg;
    logic [63:0] seed_reg;
    logic [63:0] rng_reg, rng_next;
    logic [63:0] seen_cnt [NUM_STREAMS];
    logic [CCW-1:0] stored_cnt [NUM_STREAMS];

    logic          func_reg;
    logic [3:0]    stream_reg;
    logic [125:0]  pay_reg;
    logic [9:0]    rslot_reg;
    logic [63:0]   seen_reg, seen_next;
    logic [CCW-1:0] stc_reg, stc_next;
    logic [63:0]   limit_reg, limit_next;
    logic [63:0]   z_reg, z_next;
    logic [63:0]   acc_reg, acc_next;
    logic [1:0]    mph_reg, mph_next;
    logic [63:0]   mul_a, mul_b;
    logic [31:0]   mul_x, mul_y;
    logic [63:0]   mul_p;
    logic [1:0]    act_reg, act_next;
    logic [9:0]    oslot_reg, oslot_next;
    logic [125:0]  odata_reg, odata_next;
    logic          ovalid_reg, ovalid_next;
    logic [215:0]  mdata_reg, mdata_next;
    logic [1:0]    muser_reg, muser_next;
    logic          cnt_we;

    logic          cfg_we;
    logic [CCW-1:0] cap_used;
    logic          in_range;
    logic [SW-1:0] sidx;
    logic          hit;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [125:0]  rdata;

    rsmp_pkg::div_req_t dreq;
    rsmp_pkg::div_rsp_t drsp;

    rsmp_rem u_rem (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    rsmp_store #(.AW(AW)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(pay_reg),
        .raddr(raddr), .rdata(rdata)
    );

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[3] == rsmp_pkg::REG_SEED) ? seed_reg : {53'd0, capacity_reg};

    assign cap_used = (32'(capacity_reg) > MAX_CAPACITY) ? CCW'(MAX_CAPACITY)
                                                         : CCW'(capacity_reg);
    assign in_range = 32'(stream_reg) < NUM_STREAMS;
    assign sidx     = SW'(stream_reg);
    assign raddr    = {sidx, CW'(rslot_reg)};
    assign waddr    = {sidx, CW'(oslot_reg)};
    assign hit      = (32'(rslot_reg) < 32'(stc_reg)) && (32'(rslot_reg) < MAX_CAPACITY);
    assign mul_x    = (mph_reg == 2'd2) ? mul_a[63:32] : mul_a[31:0];
    assign mul_y    = (mph_reg == 2'd1) ? mul_b[63:32] : mul_b[31:0];
    assign mul_p    = 64'(mul_x) * 64'(mul_y);

    always_comb begin
        state_next  = state_reg;
        rng_next    = rng_reg;
        seen_next   = seen_reg;
        stc_next    = stc_reg;
        limit_next  = limit_reg;
        z_next      = z_reg;
        acc_next    = acc_reg;
        mph_next    = mph_reg;
        act_next    = act_reg;
        oslot_next  = oslot_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg;
        mdata_next  = mdata_reg;
        muser_next  = muser_reg;
        dreq        = '0;
        we          = 1'b0;
        cnt_we      = 1'b0;
        mul_a       = z_reg ^ {30'd0, z_reg[63:30]};
        mul_b       = rsmp_pkg::MIX1;
        if (state_reg == rsmp_pkg::ST_MIX2) begin
            mul_a = z_reg ^ {27'd0, z_reg[63:27]};
            mul_b = rsmp_pkg::MIX2;
        end
        // Low half of the 64-bit product from three partial products.
        if (state_reg == rsmp_pkg::ST_MIX1 || state_reg == rsmp_pkg::ST_MIX2) begin
            if (mph_reg == 2'd0) begin
                acc_next = mul_p;
            end else begin
                acc_next = acc_reg + {mul_p[31:0], 32'd0};
            end
            mph_next = (mph_reg == 2'd2) ? 2'd0 : mph_reg + 2'd1;
        end
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            rsmp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = rsmp_pkg::ST_LOOK;
                end
            end
            rsmp_pkg::ST_LOOK: begin
                oslot_next = '0;
                odata_next = '0;
                seen_next  = '0;
                stc_next   = '0;
                if (!in_range) begin
                    act_next   = func_reg ? rsmp_pkg::ACT_READ : rsmp_pkg::ACT_DISCARD;
                    oslot_next = func_reg ? rslot_reg : '0;
                    state_next = rsmp_pkg::ST_OUT;
                end else if (func_reg) begin
                    act_next   = rsmp_pkg::ACT_READ;
                    oslot_next = rslot_reg;
                    seen_next  = seen_cnt[sidx];
                    stc_next   = stored_cnt[sidx];
                    state_next = rsmp_pkg::ST_RDWAIT;
                end else begin
                    seen_next = (seen_cnt[sidx] == '1) ? seen_cnt[sidx]
                                                       : seen_cnt[sidx] + 64'd1;
                    stc_next  = stored_cnt[sidx];
                    if (stored_cnt[sidx] < cap_used) begin
                        act_next   = rsmp_pkg::ACT_FREE;
                        oslot_next = 10'(stored_cnt[sidx]);
                        stc_next   = stored_cnt[sidx] + CCW'(1);
                        state_next = rsmp_pkg::ST_WRITE;
                    end else begin
                        state_next = rsmp_pkg::ST_LIMIT;
                    end
                end
            end
            rsmp_pkg::ST_RDWAIT: begin
                if (hit) begin
                    odata_next = rdata;
                end
                state_next = rsmp_pkg::ST_OUT;
            end
            rsmp_pkg::ST_LIMIT: begin
                // Rejection limit is (2^64 - bound) mod bound.
                if (!drsp.busy && !drsp.done) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = 64'd0 - seen_reg;
                    dreq.divisor  = seen_reg;
                end
                if (drsp.done) begin
                    limit_next = drsp.rem;
                    state_next = rsmp_pkg::ST_DRAW;
                end
            end
            rsmp_pkg::ST_DRAW: begin
                rng_next   = rng_reg + rsmp_pkg::GOLDEN;
                z_next     = rng_reg + rsmp_pkg::GOLDEN;
                state_next = rsmp_pkg::ST_MIX1;
            end
            rsmp_pkg::ST_MIX1: begin
                if (mph_reg == 2'd2) begin
                    z_next     = acc_next;
                    state_next = rsmp_pkg::ST_MIX2;
                end
            end
            rsmp_pkg::ST_MIX2: begin
                if (mph_reg == 2'd2) begin
                    z_next     = acc_next;
                    state_next = rsmp_pkg::ST_MIX3;
                end
            end
            rsmp_pkg::ST_MIX3: begin
                z_next     = z_reg ^ {31'd0, z_reg[63:31]};
                state_next = rsmp_pkg::ST_CHECK;
            end
            rsmp_pkg::ST_CHECK: begin
                if (z_reg >= limit_reg) begin
                    dreq.start    = 1'b1;
                    dreq.dividend = z_reg;
                    dreq.divisor  = seen_reg;
                    state_next    = rsmp_pkg::ST_MOD;
                end else begin
                    state_next = rsmp_pkg::ST_DRAW;
                end
            end
            rsmp_pkg::ST_MOD: begin
                if (drsp.done) begin
                    if (drsp.rem < 64'(cap_used)) begin
                        act_next   = rsmp_pkg::ACT_REPLACE;
                        oslot_next = drsp.rem[9:0];
                        state_next = rsmp_pkg::ST_WRITE;
                    end else begin
                        act_next   = rsmp_pkg::ACT_DISCARD;
                        oslot_next = '0;
                        cnt_we     = 1'b1;
                        state_next = rsmp_pkg::ST_OUT;
                    end
                end
            end
            rsmp_pkg::ST_WRITE: begin
                we         = 1'b1;
                cnt_we     = 1'b1;
                state_next = rsmp_pkg::ST_OUT;
            end
            rsmp_pkg::ST_OUT: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    muser_next  = act_reg;
                    mdata_next  = {5'd0, seen_reg, 11'(stc_reg), odata_reg, oslot_reg};
                    state_next  = rsmp_pkg::ST_IDLE;
                end
            end
            default: state_next = rsmp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rsmp_pkg::ST_IDLE;
            ovalid_reg   <= 1'b0;
            mph_reg      <= 2'd0;
            capacity_reg <= '0;
            seed_reg     <= '0;
            rng_reg      <= '0;
            for (int i = 0; i < NUM_STREAMS; i++) begin
                seen_cnt[i]   <= '0;
                stored_cnt[i] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            mph_reg    <= mph_next;
            if (cfg_we) begin
                if (paddr[3] == rsmp_pkg::REG_SEED) begin
                    seed_reg <= pwdata;
                    rng_reg  <= pwdata;
                end else begin
                    capacity_reg <= pwdata[10:0];
                    rng_reg      <= seed_reg;
                end
                for (int i = 0; i < NUM_STREAMS; i++) begin
                    seen_cnt[i]   <= '0;
                    stored_cnt[i] <= '0;
                end
            end else begin
                rng_reg <= rng_next;
                if (cnt_we) begin
                    seen_cnt[sidx]   <= seen_reg;
                    stored_cnt[sidx] <= stc_reg;
                end
            end
        end
        if (state_reg == rsmp_pkg::ST_IDLE && s_tvalid) begin
            func_reg   <= s_tuser;
            stream_reg <= s_tdata[3:0];
            pay_reg    <= s_tdata[129:4];
            rslot_reg  <= s_tdata[139:130];
        end
        seen_reg  <= seen_next;
        stc_reg   <= stc_next;
        limit_reg <= limit_next;
        z_reg     <= z_next;
        acc_reg   <= acc_next;
        act_reg   <= act_next;
        oslot_reg <= oslot_next;
        odata_reg <= odata_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign s_tready = (state_reg == rsmp_pkg::ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tuser  = muser_reg;
    assign m_tdata  = mdata_reg;

    property p_stall_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");

    property p_busy_not_ready;
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

    property p_write_slot;
        @(posedge aclk) disable iff (!aresetn)
        we |-> (32'(oslot_reg) < MAX_CAPACITY) && (stc_reg <= cap_used);
    endproperty
    a_write_slot: assert property (p_write_slot) else $error("slot write out of range");

endmodule

/* test/rsmp_checker.sv */
// Scoreboard for the reservoir sampler: follows register writes on the APB port,
// predicts each result beat from the accepted input beats and compares them.
// Depends on rsmp_pkg for the action codes, register indexes and generator constants.
`timescale 1ns / 1ps

module rsmp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [215:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output int           fail_count,
    output int           outstanding
);

    localparam int SLOTS   = 1024;
    localparam int STREAMS = 16;

    typedef struct {
        logic [1:0]  action;
        logic [9:0]  slot;
        logic [63:0] value;
        logic [30:0] trial;
        logic [30:0] life;
        logic [10:0] stored;
        logic [63:0] seen;
    } sample_result_t;

    sample_result_t result_fifo[$];

    logic [10:0] capacity_reg;
    logic [63:0] seed_reg;
    logic [63:0] rng_state;
    logic [63:0] seen_cnt[STREAMS];
    logic [10:0] stored_cnt[STREAMS];
    logic [63:0] value_mem[STREAMS*SLOTS];
    logic [30:0] trial_mem[STREAMS*SLOTS];
    logic [30:0] life_mem[STREAMS*SLOTS];

    function automatic logic [63:0] next_draw();
        logic [63:0] z;
        z = rng_state + rsmp_pkg::GOLDEN;
        rng_state = z;
        z = (z ^ (z >> 30)) * rsmp_pkg::MIX1;
        z = (z ^ (z >> 27)) * rsmp_pkg::MIX2;
        return z ^ (z >> 31);
    endfunction

    // Unbiased index below the bound, rejecting draws under (2^64 - bound) mod bound.
    function automatic logic [63:0] draw_index(logic [63:0] bound);
        logic [63:0] floor_val;
        logic [63:0] r;
        if (bound == 64'd0) begin
            return 64'd0;
        end
        floor_val = (64'd0 - bound) % bound;
        forever begin
            r = next_draw();
            if (r >= floor_val) begin
                return r % bound;
            end
        end
    endfunction

    function automatic void reload_counts();
        rng_state = seed_reg;
        for (int i = 0; i < STREAMS; i++) begin
            seen_cnt[i]   = '0;
            stored_cnt[i] = '0;
        end
    endfunction

    function automatic sample_result_t predict_step(logic func, logic [143:0] d);
        sample_result_t r;
        logic [3:0]  s;
        logic [9:0]  rslot;
        logic [10:0] cap;
        logic [63:0] j;
        int          base;
        logic        write_it;
        s        = d[3:0];
        rslot    = d[139:130];
        cap      = (capacity_reg > 11'd1024) ? 11'd1024 : capacity_reg;
        base     = int'(s) * SLOTS;
        write_it = 1'b0;
        r        = '{rsmp_pkg::ACT_DISCARD, 10'd0, 64'd0, 31'd0, 31'd0, 11'd0, 64'd0};
        if (func) begin
            r.action = rsmp_pkg::ACT_READ;
            r.slot   = rslot;
            if (11'(rslot) < stored_cnt[s]) begin
                r.value = value_mem[base + int'(rslot)];
                r.trial = trial_mem[base + int'(rslot)];
                r.life  = life_mem[base + int'(rslot)];
            end
        end else begin
            if (seen_cnt[s] != '1) begin
                seen_cnt[s] = seen_cnt[s] + 64'd1;
            end
            if (stored_cnt[s] < cap) begin
                r.slot        = stored_cnt[s][9:0];
                stored_cnt[s] = stored_cnt[s] + 11'd1;
                r.action      = rsmp_pkg::ACT_FREE;
                write_it      = 1'b1;
            end else begin
                j = draw_index(seen_cnt[s]);
                if (j < 64'(cap)) begin
                    r.slot   = j[9:0];
                    r.action = rsmp_pkg::ACT_REPLACE;
                    write_it = 1'b1;
                end
            end
            if (write_it) begin
                value_mem[base + int'(r.slot)] = d[67:4];
                trial_mem[base + int'(r.slot)] = d[98:68];
                life_mem[base + int'(r.slot)]  = d[129:99];
            end
        end
        r.stored = stored_cnt[s];
        r.seen   = seen_cnt[s];
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            if (fail_count <= 40) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            end
        end
    endtask

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        sample_result_t e;
        if (!aresetn) begin
            capacity_reg = '0;
            seed_reg     = '0;
            reload_counts();
            result_fifo.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[3] == rsmp_pkg::REG_SEED) begin
                    seed_reg = pwdata;
                end else begin
                    capacity_reg = pwdata[10:0];
                end
                reload_counts();
            end
            if (s_tvalid && s_tready) begin
                result_fifo.push_back(predict_step(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (result_fifo.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, got %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    e = result_fifo.pop_front();
                    compare_field("action", 64'(e.action), 64'(m_tuser));
                    compare_field("slot", 64'(e.slot), 64'(m_tdata[9:0]));
                    compare_field("value", e.value, m_tdata[73:10]);
                    compare_field("trial", 64'(e.trial), 64'(m_tdata[104:74]));
                    compare_field("life", 64'(e.life), 64'(m_tdata[135:105]));
                    compare_field("stored", 64'(e.stored), 64'(m_tdata[146:136]));
                    compare_field("seen", e.seen, m_tdata[210:147]);
                end
            end
        end
        outstanding = result_fifo.size();
    end

endmodule

/* test/testbench.sv */
// Top of the reservoir sampler testbench: clock, reset, APB register writes and
// input beats with random gaps and result back-pressure; verdict from rsmp_checker.
// Depends on rsmp_pkg, reservoir_sampler_core and rsmp_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;
    int           fail_count;
    int           outstanding;

    int           cycles;
    logic         gaps_on;
    int           hold_left;
    int           offers;
    int           reads;
    int           settings;
    logic [10:0]  cap_now;
    logic [10:0]  fill_cnt[16];
    logic         written[16][1024];

    reservoir_sampler_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rsmp_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Random result back-pressure in bursts, started only while gaps are on.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready  = 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 6);
            m_tready  = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic reg_write(logic [0:0] idx, logic [63:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 3'b000};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == rsmp_pkg::REG_CAPACITY) begin
            cap_now = (data[10:0] > 11'd1024) ? 11'd1024 : data[10:0];
        end
        for (int i = 0; i < 16; i++) begin
            fill_cnt[i] = '0;
        end
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    task automatic new_setting(logic [10:0] cap, logic [63:0] seed_val);
        settle();
        reg_write(rsmp_pkg::REG_SEED, seed_val);
        reg_write(rsmp_pkg::REG_CAPACITY, 64'(cap));
        settings++;
    endtask

    task automatic send_beat(logic func, logic [3:0] s, logic [63:0] v, logic [30:0] t,
                             logic [30:0] l, logic [9:0] rslot);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tuser  = func;
        s_tdata  = {4'd0, rslot, l, t, v, s};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (func) begin
            reads++;
        end else begin
            offers++;
            if (fill_cnt[s] < cap_now) begin
                written[s][fill_cnt[s][9:0]] = 1'b1;
                fill_cnt[s] = fill_cnt[s] + 11'd1;
            end
        end
    endtask

    task automatic offer(logic [3:0] s);
        send_beat(1'b0, s, {$urandom, $urandom}, 31'($urandom), 31'($urandom),
                  10'($urandom));
    endtask

    // Reads target a slot written under any setting, else one below the current fill; with no fill, an offer.
    task automatic read_or_offer(logic [3:0] s);
        logic [9:0] rslot;
        rslot = 10'($urandom);
        if (!written[s][rslot]) begin
            if (fill_cnt[s] == 0) begin
                offer(s);
                return;
            end
            rslot = 10'($urandom_range(0, int'(fill_cnt[s]) - 1));
        end
        send_beat(1'b1, s, {$urandom, $urandom}, 31'($urandom), 31'($urandom), rslot);
    endtask

    task automatic random_phase(int n, int hot, int hot_pct, int read_pct, logic pause);
        logic [3:0] s;
        for (int i = 0; i < n; i++) begin
            s = ($urandom_range(0, 99) < hot_pct) ? 4'(hot) : 4'($urandom);
            if (pause && i == n / 2) begin
                settle();
            end
            if ($urandom_range(0, 99) < read_pct) begin
                read_or_offer(s);
            end else begin
                offer(s);
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cycles   = 0;
        gaps_on  = 1'b0;
        hold_left = 0;
        offers   = 0;
        reads    = 0;
        settings = 1;
        cap_now  = '0;
        for (int i = 0; i < 16; i++) begin
            fill_cnt[i] = '0;
            for (int k = 0; k < 1024; k++) begin
                written[i][k] = 1'b0;
            end
        end
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Zero capacity after reset: every offer draws and is discarded.
        send_beat(1'b0, 4'd0, '1, '1, '1, '1);
        send_beat(1'b0, 4'd0, '0, '0, '0, '0);
        send_beat(1'b0, 4'd15, 64'h8000_0000_0000_0001, 31'h4000_0000, 31'd1, 10'h200);

        // Capacity of one: a fill, then draws against a growing seen count.
        new_setting(11'd1, 64'd0);
        send_beat(1'b0, 4'd0, '1, '1, '1, 10'd0);
        send_beat(1'b1, 4'd0, '0, '0, '0, 10'd0);
        send_beat(1'b0, 4'd15, 64'h0123_4567_89ab_cdef, 31'h5555_5555, 31'h2aaa_aaaa, '0);
        send_beat(1'b1, 4'd15, '0, '0, '0, 10'd0);
        repeat (4) send_beat(1'b0, 4'd0, {$urandom, $urandom}, 31'd7, 31'd9, 10'd0);
        send_beat(1'b1, 4'd0, '0, '0, '0, 10'd0);

        // Seed of all ones; counts cleared so a slot written earlier but not below the fill reads zero.
        new_setting(11'd2, '1);
        send_beat(1'b1, 4'd0, '0, '0, '0, 10'd0);
        send_beat(1'b1, 4'd15, '0, '0, '0, 10'd0);
        send_beat(1'b0, 4'd7, 64'hdead_beef_0000_ffff, 31'd3, 31'd4, 10'h3ff);
        send_beat(1'b1, 4'd7, '0, '0, '0, 10'd1);
        send_beat(1'b1, 4'd7, '0, '0, '0, 10'd0);

        gaps_on = 1'b1;
        new_setting(11'd4, {$urandom, $urandom});
        random_phase(150, 2, 60, 25, 1'b1);
        new_setting(11'd1024, '1);
        random_phase(1120, 9, 92, 20, 1'b0);
        new_setting(11'd2047, {$urandom, $urandom});
        random_phase(80, 4, 50, 25, 1'b0);
        new_setting(11'd0, {$urandom, $urandom});
        random_phase(40, 1, 50, 25, 1'b0);
        new_setting(11'd7, {$urandom, $urandom});
        random_phase(120, 11, 70, 25, 1'b0);
        gaps_on = 1'b0;
        random_phase(60, 11, 70, 25, 1'b0);

        settle();
        repeat (40) @(negedge aclk);
        $display("Covered %0d offers and %0d reads across %0d capacity and seed settings.",
                 offers, reads, settings);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/rsmp_pkg.sv
rtl/rsmp_rem.sv
rtl/rsmp_store.sv
rtl/reservoir_sampler_core.sv
test/rsmp_checker.sv
test/testbench.sv
